// File: hdl/dtiof_pkg.sv
`default_nettype none
package dtiof_pkg;

	localparam int DT_ENTRIES = 64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_MATCHED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_ZERO_NAME = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	localparam logic REG_CLASS_USER_BASE = 1'b0;
	localparam logic REG_CLASS_NONE_CODE = 1'b1;

	// search word walking down the cell chain
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] name;
		logic [15:0] owner;
		logic [15:0] row;
		logic        cls_flag;
		logic [6:0]  ridx;
		logic        found;
		logic        inserted;
		logic [7:0]  rank;
		logic [15:0] hit_name;
		logic [15:0] hit_owner;
		logic [15:0] hit_row;
		logic        hit_cls;
	} token_t;

endpackage
`default_nettype wire

// File: hdl/dtiof_cell.sv
`default_nettype none
module dtiof_cell #(
	parameter int ENTRIES    = dtiof_pkg::DT_ENTRIES,
	parameter int CELL_INDEX = 0
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  [$clog2(ENTRIES+1)-1:0]        fill,
	input  wire                                 in_vld,
	input  wire  dtiof_pkg::token_t             in_tok,
	input  wire  [$clog2(ENTRIES)-1:0]          in_idx,
	output logic                                out_vld,
	output dtiof_pkg::token_t                   out_tok,
	output logic [$clog2(ENTRIES)-1:0]          out_idx
);
	import dtiof_pkg::*;

	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int IDX_W  = $clog2(ENTRIES);

	logic [15:0] e_name_q;
	logic [15:0] e_owner_q;
	logic [15:0] e_row_q;
	logic        e_cls_q;

	logic        live;
	logic        wr;
	token_t      nxt_tok;
	logic [IDX_W-1:0] nxt_idx;

	always_comb begin
		live    = FILL_W'(CELL_INDEX) < fill;
		wr      = 1'b0;
		nxt_tok = in_tok;
		nxt_idx = in_idx;
		case (op_t'(in_tok.op))
			OP_INSERT: begin
				if (!in_tok.found && in_tok.name != 16'd0) begin
					if (live && e_name_q == in_tok.name && e_owner_q == in_tok.owner
							&& e_cls_q == in_tok.cls_flag) begin
						nxt_tok.found     = 1'b1;
						nxt_tok.hit_name  = e_name_q;
						nxt_tok.hit_owner = e_owner_q;
						nxt_tok.hit_row   = e_row_q;
						nxt_tok.hit_cls   = e_cls_q;
						nxt_idx           = IDX_W'(CELL_INDEX);
					end else if (FILL_W'(CELL_INDEX) == fill) begin
						wr                = in_vld;
						nxt_tok.found     = 1'b1;
						nxt_tok.inserted  = 1'b1;
						nxt_tok.hit_name  = in_tok.name;
						nxt_tok.hit_owner = in_tok.owner;
						nxt_tok.hit_row   = in_tok.row;
						nxt_tok.hit_cls   = in_tok.cls_flag;
						nxt_idx           = IDX_W'(CELL_INDEX);
					end
				end
			end
			OP_READ: begin
				if (live && int'(in_tok.ridx) == CELL_INDEX) begin
					nxt_tok.found     = 1'b1;
					nxt_tok.hit_name  = e_name_q;
					nxt_tok.hit_owner = e_owner_q;
					nxt_tok.hit_row   = e_row_q;
					nxt_tok.hit_cls   = e_cls_q;
					nxt_idx           = IDX_W'(CELL_INDEX);
				end
			end
			OP_QUERY: begin
				if (!in_tok.found && live && e_cls_q) begin
					if (e_name_q == in_tok.name) begin
						nxt_tok.found     = 1'b1;
						nxt_tok.hit_name  = e_name_q;
						nxt_tok.hit_owner = e_owner_q;
						nxt_tok.hit_row   = e_row_q;
						nxt_tok.hit_cls   = e_cls_q;
						nxt_idx           = IDX_W'(CELL_INDEX);
					end else begin
						nxt_tok.rank = in_tok.rank + 8'd1;
					end
				end
			end
			default: begin
				nxt_tok = in_tok;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			e_name_q  <= in_tok.name;
			e_owner_q <= in_tok.owner;
			e_row_q   <= in_tok.row;
			e_cls_q   <= in_tok.cls_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_tok <= nxt_tok;
		out_idx <= nxt_idx;
	end

endmodule
`default_nettype wire

// File: hdl/definition_table_insert_or_find.sv
`default_nettype none
// Definition table: insert-or-find on (name, owner, class flag), read by index, and
// class-id query, over up to ENTRIES entries held one per cell in a chain. An accepted
// word is handed cell to cell, one cell per clock, each cell comparing against its own
// entry (and storing a new one at the fill position); the result leaves the last cell.
// One word is in flight at a time: the accepted word is registered, walks the cell chain
// and is registered again as the result; the next word is taken from the cycle after
// the result has been taken. Reset empties the table at once. s_axis_tuser carries the
// operation.
module definition_table_insert_or_find #(
	parameter int ENTRIES = dtiof_pkg::DT_ENTRIES
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [7:0]  cfg_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// key_name[15:0], key_owner[31:16], key_row[47:32], key_cls[48], read_index[55:49]
	input  wire  [55:0] s_axis_tdata,
	// operation[1:0]
	input  wire  [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// status[2:0], slot[8:3], out_name[24:9], out_owner[40:25], out_row[56:41],
	// out_cls[57], entry_count[64:58], class_id[72:65], zero[79:73]
	output logic [79:0] m_axis_tdata
);
	import dtiof_pkg::*;

	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int IDX_W  = $clog2(ENTRIES);

	logic [7:0]        class_user_base_q;
	logic [7:0]        class_none_code_q;
	logic [FILL_W-1:0] fill_q;
	logic              busy_q;
	logic              tok_vld_q;
	token_t            tok_q;
	logic [72:0]       res_q;
	logic              res_vld_q;

	logic              ch_vld [ENTRIES+1];
	token_t            ch_tok [ENTRIES+1];
	logic [IDX_W-1:0]  ch_idx [ENTRIES+1];

	logic              s_acc;
	token_t            tok_in;
	token_t            tl;
	logic [FILL_W-1:0] fill_nxt;
	status_t           st;
	logic [7:0]        cid;

	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy_q;
	assign m_axis_tvalid = res_vld_q;
	assign m_axis_tdata  = {7'd0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_user_base_q <= 8'd1;
			class_none_code_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLASS_USER_BASE: class_user_base_q <= cfg_data;
				REG_CLASS_NONE_CODE: class_none_code_q <= cfg_data;
				default: class_user_base_q <= class_user_base_q;
			endcase
		end
	end

	always_comb begin
		tok_in          = '0;
		tok_in.op       = s_axis_tuser;
		tok_in.name     = s_axis_tdata[15:0];
		tok_in.owner    = s_axis_tdata[31:16];
		tok_in.row      = s_axis_tdata[47:32];
		tok_in.cls_flag = s_axis_tdata[48];
		tok_in.ridx     = s_axis_tdata[55:49];
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			tok_q <= tok_in;
		end
	end

	assign ch_vld[0] = tok_vld_q;
	assign ch_tok[0] = tok_q;
	assign ch_idx[0] = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		dtiof_cell #(
			.ENTRIES    (ENTRIES),
			.CELL_INDEX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.fill    (fill_q),
			.in_vld  (ch_vld[g]),
			.in_tok  (ch_tok[g]),
			.in_idx  (ch_idx[g]),
			.out_vld (ch_vld[g+1]),
			.out_tok (ch_tok[g+1]),
			.out_idx (ch_idx[g+1])
		);
	end

	assign tl = ch_tok[ENTRIES];

	always_comb begin
		fill_nxt = fill_q + FILL_W'(tl.inserted);
		cid      = 8'd0;
		case (op_t'(tl.op))
			OP_INSERT: begin
				if (tl.name == 16'd0) begin
					st = ST_ZERO_NAME;
				end else if (tl.found) begin
					st = tl.inserted ? ST_INSERTED : ST_MATCHED;
				end else begin
					st = ST_FULL;
				end
			end
			OP_READ: begin
				st = tl.found ? ST_MATCHED : ST_NOT_FOUND;
			end
			OP_QUERY: begin
				st  = tl.found ? ST_MATCHED : ST_NOT_FOUND;
				cid = tl.found ? class_user_base_q + tl.rank : class_none_code_q;
			end
			default: begin
				st = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ch_vld[ENTRIES]) begin
			res_q <= {cid, 7'(fill_nxt), tl.hit_cls, tl.hit_row, tl.hit_owner,
				tl.hit_name, 6'(ch_idx[ENTRIES]), st};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			tok_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
			fill_q    <= '0;
		end else begin
			tok_vld_q <= s_acc;
			if (s_acc) begin
				busy_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				busy_q <= 1'b0;
			end
			if (ch_vld[ENTRIES]) begin
				res_vld_q <= 1'b1;
				fill_q    <= fill_nxt;
			end else if (m_axis_tready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import dtiof_pkg::*;

	localparam int ENTRIES = DT_ENTRIES;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = ENTRIES + 8;

	// laid out as on m_axis_tdata, status in the low bits
	typedef struct packed {
		logic [6:0]  pad;
		logic [7:0]  class_id;
		logic [6:0]  count;
		logic        cls;
		logic [15:0] row;
		logic [15:0] owner;
		logic [15:0] name;
		logic [5:0]  slot;
		logic [2:0]  status;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// key_name, key_owner, key_row, key_cls, read_index
	logic [55:0] s_axis_tdata = '0;
	// operation
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// status, slot, out_name, out_owner, out_row, out_cls, entry_count, class_id, zero
	logic [79:0] m_axis_tdata;

	// shadow of the definition table
	logic [15:0] tbl_name [ENTRIES];
	logic [15:0] tbl_owner [ENTRIES];
	logic [15:0] tbl_row [ENTRIES];
	logic        tbl_cls [ENTRIES];
	int          fill_cnt = 0;
	logic [7:0]  user_base = 8'd1;
	logic [7:0]  none_code = 8'd0;

	result_t pending_results [$];
	int      mismatch_count = 0;
	int      sender_idle_pct = 0;
	int      sink_stall_pct = 0;

	definition_table_insert_or_find DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	function automatic result_t table_step(input logic [1:0] op, input logic [15:0] name,
			input logic [15:0] owner, input logic [15:0] row, input logic cls,
			input logic [6:0] ridx);
		result_t r;
		int hit;
		logic [7:0] rank;
		r = '0;
		r.status = ST_NOT_FOUND;
		hit = -1;
		rank = '0;
		case (op)
			OP_INSERT: begin
				if (name == '0) begin
					r.status = ST_ZERO_NAME;
				end else begin
					for (int i = 0; i < fill_cnt; i++)
						if (hit < 0 && tbl_name[i] == name && tbl_owner[i] == owner
								&& tbl_cls[i] == cls)
							hit = i;
					if (hit >= 0) begin
						r.status = ST_MATCHED;
					end else if (fill_cnt >= ENTRIES) begin
						r.status = ST_FULL;
					end else begin
						hit = fill_cnt;
						tbl_name[hit] = name;
						tbl_owner[hit] = owner;
						tbl_row[hit] = row;
						tbl_cls[hit] = cls;
						fill_cnt++;
						r.status = ST_INSERTED;
					end
				end
			end
			OP_READ: begin
				if (ridx < fill_cnt) begin
					hit = int'(ridx);
					r.status = ST_MATCHED;
				end
			end
			OP_QUERY: begin
				r.class_id = none_code;
				// rank = class entries ahead of the first class hit
				for (int i = 0; i < fill_cnt; i++)
					if (hit < 0 && tbl_cls[i]) begin
						if (tbl_name[i] == name)
							hit = i;
						else
							rank++;
					end
				if (hit >= 0) begin
					r.status = ST_MATCHED;
					r.class_id = user_base + rank;
				end
			end
			default: ;
		endcase
		if (hit >= 0) begin
			r.slot = 6'(hit);
			r.name = tbl_name[hit];
			r.owner = tbl_owner[hit];
			r.row = tbl_row[hit];
			r.cls = tbl_cls[hit];
		end
		r.count = 7'(fill_cnt);
		return r;
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("st=%0d slot=%0d name=%h owner=%h row=%h cls=%0d cnt=%0d cid=%0d pad=%h",
			r.status, r.slot, r.name, r.owner, r.row, r.cls, r.count, r.class_id, r.pad);
	endfunction

	task automatic report_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%t %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_results.size() == 0) begin
				report_error({"unexpected word: ", show(got)});
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.slot !== want.slot
						|| got.name !== want.name || got.owner !== want.owner
						|| got.row !== want.row || got.cls !== want.cls
						|| got.count !== want.count || got.class_id !== want.class_id
						|| got.pad !== want.pad)
					report_error({"mismatch: expected ", show(want), " got ", show(got)});
			end
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [15:0] name,
			input logic [15:0] owner, input logic [15:0] row, input logic cls,
			input logic [6:0] ridx);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {ridx, cls, row, owner, name};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(table_step(op, name, owner, row, cls, ridx));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] base, input logic [7:0] none);
		cfg_we <= 1'b1;
		cfg_index <= REG_CLASS_USER_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= REG_CLASS_NONE_CODE;
		cfg_data <= none;
		@(posedge clk);
		cfg_we <= 1'b0;
		user_base = base;
		none_code = none;
	endtask

	task automatic test_empty_table();
		send_word(OP_INSERT, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 7'h7F);
		send_word(OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 7'd0);
		send_word(OP_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 7'h7F);
		send_word(OP_QUERY, 16'h0005, 16'h0000, 16'h0000, 1'b0, 7'd0);
		send_word(OP_QUERY, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 7'h7F);
		send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 7'h7F);
	endtask

	task automatic test_insert_find();
		send_word(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 7'h7F);
		send_word(OP_INSERT, 16'h0001, 16'h0000, 16'h0000, 1'b0, 7'd0);
		// same name and owner, other class flag: new entry
		send_word(OP_INSERT, 16'h0001, 16'h0000, 16'h1234, 1'b1, 7'd0);
		send_word(OP_INSERT, 16'h0001, 16'h0000, 16'h5555, 1'b0, 7'd3);
		send_word(OP_INSERT, 16'hFFFF, 16'h0000, 16'h0007, 1'b1, 7'd0);
		send_word(OP_INSERT, 16'h0007, 16'h0003, 16'h0009, 1'b0, 7'd0);
		send_word(OP_INSERT, 16'h0000, 16'h0003, 16'h0009, 1'b0, 7'd0);
	endtask

	task automatic test_read_index();
		send_word(OP_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 7'd0);
		send_word(OP_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 7'd5);
		send_word(OP_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 7'd6);
		send_word(OP_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 7'd64);
	endtask

	task automatic test_class_query();
		send_word(OP_QUERY, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 7'd0);
		// rank 1 on base 255 wraps to 0
		send_word(OP_QUERY, 16'h0001, 16'h0000, 16'h0000, 1'b0, 7'd0);
		send_word(OP_QUERY, 16'h0007, 16'h0000, 16'h0000, 1'b1, 7'd0);
		send_word(OP_QUERY, 16'h0002, 16'h0000, 16'h0000, 1'b0, 7'd0);
		wait_drained();
		set_config(8'd0, 8'd0);
		send_word(OP_QUERY, 16'h0001, 16'h0000, 16'h0000, 1'b0, 7'd0);
		send_word(OP_QUERY, 16'h1234, 16'h0000, 16'h0000, 1'b0, 7'd0);
	endtask

	task automatic test_random(input int n, input int idle_pct, input int stall_pct,
			input bit pause_mid);
		int pick, k;
		logic [1:0] op;
		logic [15:0] nm, ow, rw;
		logic cl;
		logic [6:0] ix;
		sender_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2)
				wait_drained();
			nm = 16'($urandom);
			ow = 16'($urandom);
			rw = 16'($urandom);
			cl = 1'($urandom);
			ix = 7'($urandom);
			k = (fill_cnt > 0) ? $urandom_range(0, fill_cnt - 1) : 0;
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				op = OP_INSERT;
				pick = $urandom_range(0, 99);
				if (pick < 55 && fill_cnt > 0) begin
					nm = tbl_name[k];
					ow = tbl_owner[k];
					cl = tbl_cls[k];
				end else if (pick >= 55 && pick < 62) begin
					nm = '0;
				end else begin
					if (pick < 92)
						nm = 16'($urandom_range(1, 40));
					if ($urandom_range(0, 4) != 0)
						ow = 16'($urandom_range(0, 3));
				end
			end else if (pick < 65) begin
				op = OP_READ;
				if ($urandom_range(0, 1) == 1 && fill_cnt > 0)
					ix = 7'(k);
			end else if (pick < 97) begin
				op = OP_QUERY;
				pick = $urandom_range(0, 99);
				if (pick < 70 && fill_cnt > 0)
					nm = tbl_name[k];
				else if (pick < 85)
					nm = 16'($urandom_range(0, 40));
			end else begin
				op = OP_UNUSED;
			end
			send_word(op, nm, ow, rw, cl, ix);
		end
	endtask

	task automatic test_table_full();
		int last_cls;
		sender_idle_pct = 10;
		sink_stall_pct = 10;
		while (fill_cnt < ENTRIES)
			send_word(OP_INSERT, 16'($urandom_range(1, 65535)), 16'($urandom),
				16'($urandom), 1'($urandom), 7'($urandom));
		repeat (3)
			send_word(OP_INSERT, 16'($urandom_range(1, 65535)), 16'($urandom),
				16'($urandom), 1'($urandom), 7'($urandom));
		send_word(OP_INSERT, tbl_name[ENTRIES - 1], tbl_owner[ENTRIES - 1], 16'($urandom),
			tbl_cls[ENTRIES - 1], 7'($urandom));
		send_word(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 7'd63);
		send_word(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 7'd64);
		last_cls = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_cls[i])
				last_cls = i;
		if (last_cls >= 0)
			send_word(OP_QUERY, tbl_name[last_cls], 16'($urandom), 16'($urandom),
				1'($urandom), 7'($urandom));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(8'd255, 8'd255);
		test_empty_table();
		test_insert_find();
		test_read_index();
		test_class_query();
		test_random(330, 0, 0, 1'b0);
		wait_drained();
		set_config(8'd1, 8'd0);
		test_random(330, 65, 0, 1'b0);
		wait_drained();
		set_config(8'd255, 8'd0);
		test_random(330, 0, 65, 1'b1);
		wait_drained();
		set_config(8'($urandom), 8'($urandom));
		test_random(330, 27, 27, 1'b0);
		wait_drained();
		set_config(8'd0, 8'd255);
		test_table_full();
		wait_drained();
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
